FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/sdm_pkg.sv
// ----------------------------------------------------------------------------
// Soft symbol demapper package
// Shared widths, constants, register indexes and control types.
// ----------------------------------------------------------------------------
package sdm_pkg;

  localparam int MaxPointsDef = 64;
  localparam int PointLimit   = 64;
  localparam int CountW       = 7;
  localparam int IdxW         = 6;
  localparam int SeriesOrder  = 12;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 16;

  // exp(-1) in Q2.30 as produced by the truncated series.
  localparam logic [28:0] ExpOne = 29'd395007543;

  localparam logic [CfgIdxW-1:0] CfgNumPoints   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInvNoiseVar = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgProbFloor   = 2'd2;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_START,
    OP_TAB_RD,
    OP_ROT_A,
    OP_ROT_B,
    OP_ROT_C,
    OP_ROT_D,
    OP_DIFF,
    OP_SQ_RE,
    OP_SQ_IM,
    OP_MET_MUL,
    OP_MET_WR,
    OP_WK_RD,
    OP_EXP_INIT,
    OP_TERM_MUL,
    OP_DIV_STEP,
    OP_TERM_ACC,
    OP_POW_STEP,
    OP_W_WR,
    OP_NRM_INIT,
    OP_NRM_STEP,
    OP_OUT_LOAD
  } sdm_op_e;

  typedef struct packed {
    sdm_op_e op;
    logic    idx_inc;
    logic    idx_clr;
  } sdm_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic last_pt;
    logic big;
    logic k_last;
    logic pow_done;
    logic cnt_done;
    logic out_free;
  } sdm_status_t;

endpackage

FILE: design/sdm_ctrl.sv
// ----------------------------------------------------------------------------
// Soft symbol demapper controller
// Sequences the metric, exponent and normalization passes over the points.
// ----------------------------------------------------------------------------
module sdm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                demod_i,
  input  sdm_pkg::sdm_status_t status_i,
  output sdm_pkg::sdm_cmd_t   cmd_o,
  output logic                busy_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CHK    = 5'd1;
  localparam logic [4:0] S_M_RD   = 5'd2;
  localparam logic [4:0] S_M_A    = 5'd3;
  localparam logic [4:0] S_M_B    = 5'd4;
  localparam logic [4:0] S_M_C    = 5'd5;
  localparam logic [4:0] S_M_D    = 5'd6;
  localparam logic [4:0] S_M_DF   = 5'd7;
  localparam logic [4:0] S_M_SR   = 5'd8;
  localparam logic [4:0] S_M_SI   = 5'd9;
  localparam logic [4:0] S_M_MM   = 5'd10;
  localparam logic [4:0] S_M_WR   = 5'd11;
  localparam logic [4:0] S_E_RD   = 5'd12;
  localparam logic [4:0] S_E_SET  = 5'd13;
  localparam logic [4:0] S_E_TM   = 5'd14;
  localparam logic [4:0] S_E_DV   = 5'd15;
  localparam logic [4:0] S_E_AC   = 5'd16;
  localparam logic [4:0] S_E_PW   = 5'd17;
  localparam logic [4:0] S_E_WR   = 5'd18;
  localparam logic [4:0] S_N_RD   = 5'd19;
  localparam logic [4:0] S_N_INIT = 5'd20;
  localparam logic [4:0] S_N_DV   = 5'd21;
  localparam logic [4:0] S_N_OUT  = 5'd22;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = sdm_pkg::OP_NOP;
    cmd_o.idx_inc = 1'b0;
    cmd_o.idx_clr = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (demod_i) begin
          cmd_o.op = sdm_pkg::OP_START;
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        state_d = status_i.n_zero ? S_IDLE : S_M_RD;
      end
      S_M_RD: begin
        cmd_o.op = sdm_pkg::OP_TAB_RD;
        state_d  = S_M_A;
      end
      S_M_A: begin
        cmd_o.op = sdm_pkg::OP_ROT_A;
        state_d  = S_M_B;
      end
      S_M_B: begin
        cmd_o.op = sdm_pkg::OP_ROT_B;
        state_d  = S_M_C;
      end
      S_M_C: begin
        cmd_o.op = sdm_pkg::OP_ROT_C;
        state_d  = S_M_D;
      end
      S_M_D: begin
        cmd_o.op = sdm_pkg::OP_ROT_D;
        state_d  = S_M_DF;
      end
      S_M_DF: begin
        cmd_o.op = sdm_pkg::OP_DIFF;
        state_d  = S_M_SR;
      end
      S_M_SR: begin
        cmd_o.op = sdm_pkg::OP_SQ_RE;
        state_d  = S_M_SI;
      end
      S_M_SI: begin
        cmd_o.op = sdm_pkg::OP_SQ_IM;
        state_d  = S_M_MM;
      end
      S_M_MM: begin
        cmd_o.op = sdm_pkg::OP_MET_MUL;
        state_d  = S_M_WR;
      end
      S_M_WR: begin
        cmd_o.op = sdm_pkg::OP_MET_WR;
        if (status_i.last_pt) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_E_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_M_RD;
        end
      end
      S_E_RD: begin
        cmd_o.op = sdm_pkg::OP_WK_RD;
        state_d  = S_E_SET;
      end
      S_E_SET: begin
        cmd_o.op = sdm_pkg::OP_EXP_INIT;
        state_d  = status_i.big ? S_E_WR : S_E_TM;
      end
      S_E_TM: begin
        cmd_o.op = sdm_pkg::OP_TERM_MUL;
        state_d  = S_E_DV;
      end
      S_E_DV: begin
        cmd_o.op = sdm_pkg::OP_DIV_STEP;
        if (status_i.cnt_done) begin
          state_d = S_E_AC;
        end
      end
      S_E_AC: begin
        cmd_o.op = sdm_pkg::OP_TERM_ACC;
        state_d  = status_i.k_last ? S_E_PW : S_E_TM;
      end
      S_E_PW: begin
        if (status_i.pow_done) begin
          state_d = S_E_WR;
        end else begin
          cmd_o.op = sdm_pkg::OP_POW_STEP;
        end
      end
      S_E_WR: begin
        cmd_o.op = sdm_pkg::OP_W_WR;
        if (status_i.last_pt) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_N_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_E_RD;
        end
      end
      S_N_RD: begin
        cmd_o.op = sdm_pkg::OP_WK_RD;
        state_d  = S_N_INIT;
      end
      S_N_INIT: begin
        cmd_o.op = sdm_pkg::OP_NRM_INIT;
        state_d  = S_N_DV;
      end
      S_N_DV: begin
        cmd_o.op = sdm_pkg::OP_NRM_STEP;
        if (status_i.cnt_done) begin
          state_d = S_N_OUT;
        end
      end
      S_N_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = sdm_pkg::OP_OUT_LOAD;
          if (status_i.last_pt) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_N_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: design/sdm_dp.sv
// ----------------------------------------------------------------------------
// Soft symbol demapper datapath
// Point table, metric and weight store, shared arithmetic and output register.
// ----------------------------------------------------------------------------
module sdm_dp #(
  parameter int MaxPoints = sdm_pkg::MaxPointsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sdm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sdm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_acc_i,
  input  logic                          req_type_i,
  input  logic [5:0]                    point_index_i,
  input  logic signed [15:0]            point_re_i,
  input  logic signed [15:0]            point_im_i,
  input  logic signed [15:0]            recv_re_i,
  input  logic signed [15:0]            recv_im_i,
  input  logic signed [15:0]            rot_re_i,
  input  logic signed [15:0]            rot_im_i,
  input  sdm_pkg::sdm_cmd_t             cmd_i,
  output sdm_pkg::sdm_status_t          status_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [5:0]                    symbol_index_o,
  output logic [15:0]                   probability_o,
  output logic                          last_o
);

  localparam int Cap = (MaxPoints < sdm_pkg::PointLimit) ? MaxPoints : sdm_pkg::PointLimit;
  localparam int AW  = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam logic [sdm_pkg::CountW-1:0] CapCount = sdm_pkg::CountW'(Cap);

  logic [6:0]  num_points_q;
  logic [15:0] inv_q;
  logic [14:0] floor_q;
  logic [6:0]  n_eff_q;
  logic [5:0]  idx_q;
  logic        out_valid_q;

  logic [31:0] tab_mem [MaxPoints];
  logic [31:0] wk_mem  [MaxPoints];
  logic [31:0] tab_q;
  logic [31:0] wk_q;

  logic signed [15:0] y_re_q, y_im_q, r_re_q, r_im_q;
  logic signed [31:0] pa_q;
  logic signed [32:0] xre_q, xim_q;
  logic signed [19:0] dre_q, dim_q;
  logic [37:0] dist_q;
  logic [53:0] mp_q;
  logic [31:0] min_q;
  logic [15:0] f_q;
  logic [3:0]  n_q;
  logic        big_q;
  logic [30:0] term_q;
  logic [30:0] esum_q;
  logic [3:0]  k_q;
  logic [31:0] dq_q;
  logic [4:0]  rem_q;
  logic [4:0]  cnt_q;
  logic [36:0] sum_q;
  logic [37:0] nr_q;
  logic [16:0] nq_q;
  logic [5:0]  sym_q;
  logic [15:0] prob_q;
  logic        last_q;

  logic [AW-1:0] addr, tab_wa;
  logic          tab_we;
  logic          last_pt;

  logic signed [15:0] pre, pim, rot_x, rot_y;
  logic signed [31:0] rot_p;
  logic signed [32:0] xre_rnd, xim_rnd;
  logic signed [18:0] xr_re, xr_im;
  logic signed [19:0] sq_op;
  logic signed [39:0] sq_p;
  logic [54:0] met_rnd;
  logic [36:0] met_wide;
  logic [31:0] metric;
  logic [31:0] delta;
  logic [46:0] term_p;
  logic [4:0]  div_r;
  logic [31:0] div_d;
  logic [59:0] pow_p;
  logic [60:0] pow_rnd;
  logic [30:0] w_dat;
  logic [46:0] num;
  logic [37:0] nrm_t;
  logic        nrm_ge;
  logic [16:0] lo, hi_raw, hi, clip;

  assign addr    = AW'(idx_q);
  assign tab_wa  = AW'(point_index_i);
  assign tab_we  = in_acc_i && !req_type_i && (9'(point_index_i) < 9'(MaxPoints));
  assign last_pt = ({1'b0, idx_q} == (n_eff_q - 7'd1));

  assign pre = tab_q[31:16];
  assign pim = tab_q[15:0];

  always_comb begin
    rot_x = pre;
    rot_y = r_re_q;
    case (cmd_i.op)
      sdm_pkg::OP_ROT_B: begin
        rot_x = pim;
        rot_y = r_im_q;
      end
      sdm_pkg::OP_ROT_C: begin
        rot_x = pim;
        rot_y = r_re_q;
      end
      sdm_pkg::OP_ROT_D: begin
        rot_x = pre;
        rot_y = r_im_q;
      end
      default: begin
      end
    endcase
  end

  assign rot_p   = rot_x * rot_y;
  assign xre_rnd = xre_q + 33'sd8192;
  assign xim_rnd = xim_q + 33'sd8192;
  assign xr_re   = xre_rnd[32:14];
  assign xr_im   = xim_rnd[32:14];

  assign sq_op = (cmd_i.op == sdm_pkg::OP_SQ_IM) ? dim_q : dre_q;
  assign sq_p  = sq_op * sq_op;

  assign met_rnd  = {1'b0, mp_q} + 55'd131072;
  assign met_wide = met_rnd[54:18];
  assign metric   = (|met_wide[36:32]) ? 32'hFFFF_FFFF : met_wide[31:0];

  assign delta  = wk_q - min_q;
  assign term_p = 47'(term_q) * 47'(f_q);

  always_comb begin
    div_r = rem_q;
    div_d = dq_q;
    for (int j = 0; j < 8; j++) begin
      div_r = {div_r[3:0], div_d[31]};
      div_d = {div_d[30:0], 1'b0};
      if (div_r >= {1'b0, k_q}) begin
        div_r    = div_r - {1'b0, k_q};
        div_d[0] = 1'b1;
      end
    end
  end

  assign pow_p   = 60'(esum_q) * 60'(sdm_pkg::ExpOne);
  assign pow_rnd = {1'b0, pow_p} + 61'd536870912;
  assign w_dat   = big_q ? 31'd0 : esum_q;

  assign num    = {wk_q[30:0], 16'd0} + 47'(sum_q >> 1);
  assign nrm_t  = {nr_q[36:0], nq_q[16]};
  assign nrm_ge = (nrm_t >= 38'(sum_q));

  assign lo     = 17'(floor_q);
  assign hi_raw = 17'd65536 - 17'(floor_q);
  assign hi     = (hi_raw > 17'd65535) ? 17'd65535 : hi_raw;
  assign clip   = (nq_q < lo) ? lo : ((nq_q > hi) ? hi : nq_q);

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_wa] <= {point_re_i, point_im_i};
    end
    if (cmd_i.op == sdm_pkg::OP_TAB_RD) begin
      tab_q <= tab_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sdm_pkg::OP_MET_WR) begin
      wk_mem[addr] <= metric;
    end else if (cmd_i.op == sdm_pkg::OP_W_WR) begin
      wk_mem[addr] <= {1'b0, w_dat};
    end
    if (cmd_i.op == sdm_pkg::OP_WK_RD) begin
      wk_q <= wk_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= 7'd4;
      inv_q        <= 16'd256;
      floor_q      <= 15'd1;
      n_eff_q      <= 7'd0;
      idx_q        <= 6'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sdm_pkg::CfgNumPoints:   num_points_q <= cfg_data_i[6:0];
          sdm_pkg::CfgInvNoiseVar: inv_q        <= cfg_data_i;
          sdm_pkg::CfgProbFloor:   floor_q      <= cfg_data_i[14:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.op == sdm_pkg::OP_START) begin
        n_eff_q <= (num_points_q > CapCount) ? CapCount : num_points_q;
        idx_q   <= 6'd0;
      end else if (cmd_i.idx_clr) begin
        idx_q <= 6'd0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 6'd1;
      end
      if (cmd_i.op == sdm_pkg::OP_OUT_LOAD) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_i && req_type_i) begin
      y_re_q <= recv_re_i;
      y_im_q <= recv_im_i;
      r_re_q <= rot_re_i;
      r_im_q <= rot_im_i;
    end
    case (cmd_i.op)
      sdm_pkg::OP_START: begin
        min_q <= 32'hFFFF_FFFF;
        sum_q <= 37'd0;
      end
      sdm_pkg::OP_ROT_A: pa_q  <= rot_p;
      sdm_pkg::OP_ROT_B: xre_q <= 33'(pa_q) - 33'(rot_p);
      sdm_pkg::OP_ROT_C: pa_q  <= rot_p;
      sdm_pkg::OP_ROT_D: xim_q <= 33'(pa_q) + 33'(rot_p);
      sdm_pkg::OP_DIFF: begin
        dre_q <= 20'(y_re_q) - 20'(xr_re);
        dim_q <= 20'(y_im_q) - 20'(xr_im);
      end
      sdm_pkg::OP_SQ_RE:   dist_q <= sq_p[37:0];
      sdm_pkg::OP_SQ_IM:   dist_q <= dist_q + sq_p[37:0];
      sdm_pkg::OP_MET_MUL: mp_q   <= 54'(dist_q) * 54'(inv_q);
      sdm_pkg::OP_MET_WR: begin
        if (metric < min_q) begin
          min_q <= metric;
        end
      end
      sdm_pkg::OP_EXP_INIT: begin
        f_q    <= delta[15:0];
        n_q    <= delta[19:16];
        big_q  <= |delta[31:20];
        term_q <= 31'h4000_0000;
        esum_q <= 31'h4000_0000;
        k_q    <= 4'd1;
      end
      sdm_pkg::OP_TERM_MUL: begin
        dq_q  <= {1'b0, term_p[46:16]};
        rem_q <= 5'd0;
        cnt_q <= 5'd3;
      end
      sdm_pkg::OP_DIV_STEP: begin
        dq_q  <= div_d;
        rem_q <= div_r;
        cnt_q <= cnt_q - 5'd1;
      end
      sdm_pkg::OP_TERM_ACC: begin
        term_q <= dq_q[30:0];
        esum_q <= k_q[0] ? (esum_q - dq_q[30:0]) : (esum_q + dq_q[30:0]);
        k_q    <= k_q + 4'd1;
      end
      sdm_pkg::OP_POW_STEP: begin
        esum_q <= pow_rnd[60:30];
        n_q    <= n_q - 4'd1;
      end
      sdm_pkg::OP_W_WR: sum_q <= sum_q + 37'(w_dat);
      sdm_pkg::OP_NRM_INIT: begin
        nr_q  <= 38'(num[46:17]);
        nq_q  <= num[16:0];
        cnt_q <= 5'd16;
      end
      sdm_pkg::OP_NRM_STEP: begin
        nr_q  <= nrm_ge ? (nrm_t - 38'(sum_q)) : nrm_t;
        nq_q  <= {nq_q[15:0], nrm_ge};
        cnt_q <= cnt_q - 5'd1;
      end
      sdm_pkg::OP_OUT_LOAD: begin
        sym_q  <= idx_q;
        prob_q <= clip[15:0];
        last_q <= last_pt;
      end
      default: begin
      end
    endcase
  end

  assign status_o.n_zero   = (n_eff_q == 7'd0);
  assign status_o.last_pt  = last_pt;
  assign status_o.big      = |delta[31:20];
  assign status_o.k_last   = (k_q == 4'(sdm_pkg::SeriesOrder));
  assign status_o.pow_done = (n_q == 4'd0);
  assign status_o.cnt_done = (cnt_q == 5'd0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign symbol_index_o = sym_q;
  assign probability_o  = prob_q;
  assign last_o         = last_q;

endmodule

FILE: design/soft_symbol_demapper_top.sv
// ----------------------------------------------------------------------------
// Soft symbol demapper top level
// A load item does not make the block busy. A demodulate item holds the input
// stalled through the metric, exponent and normalization passes over the points;
// a point whose metric gap is 16 or more skips the exponent series and power steps
// of the shared units. Reset is asynchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module soft_symbol_demapper_top #(
  parameter int MaxPoints = sdm_pkg::MaxPointsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sdm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sdm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [5:0]                    point_index_i,
  input  logic signed [15:0]            point_re_i,
  input  logic signed [15:0]            point_im_i,
  input  logic signed [15:0]            recv_re_i,
  input  logic signed [15:0]            recv_im_i,
  input  logic signed [15:0]            rot_re_i,
  input  logic signed [15:0]            rot_im_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [5:0]                    symbol_index_o,
  output logic [15:0]                   probability_o,
  output logic                          last_o
);

  sdm_pkg::sdm_cmd_t    cmd;
  sdm_pkg::sdm_status_t status;
  logic                 busy;
  logic                 in_acc;

  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !busy;

  sdm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .demod_i  (in_acc && req_type_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  sdm_dp #(
    .MaxPoints (MaxPoints)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_acc_i       (in_acc),
    .req_type_i     (req_type_i),
    .point_index_i  (point_index_i),
    .point_re_i     (point_re_i),
    .point_im_i     (point_im_i),
    .recv_re_i      (recv_re_i),
    .recv_im_i      (recv_im_i),
    .rot_re_i       (rot_re_i),
    .rot_im_i       (rot_im_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .symbol_index_o (symbol_index_o),
    .probability_o  (probability_o),
    .last_o         (last_o)
  );

  `SDM_ASSERT(a_demod_busy, (in_acc && req_type_i) |=> in_stall_o, "Demodulate item did not start work.")
  `SDM_ASSERT(a_last_idle, (cmd.op == sdm_pkg::OP_OUT_LOAD && status.last_pt) |=> !in_stall_o, "Block not idle after the last item.")
  `SDM_ASSERT(a_load_free, (cmd.op == sdm_pkg::OP_OUT_LOAD) |-> status.out_free, "Output register overwritten while held.")
  `SDM_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !in_stall_o, "Block busy during reset.")

endmodule

FILE: dv/soft_symbol_demapper_checker.sv
// ----------------------------------------------------------------------------
// Soft symbol demapper checker
// Watches the configuration port and both item channels, predicts the
// posterior probabilities of every demodulate item and compares each output
// item with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module soft_symbol_demapper_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sdm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sdm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          req_type_i,
  input  logic [5:0]                    point_index_i,
  input  logic signed [15:0]            point_re_i,
  input  logic signed [15:0]            point_im_i,
  input  logic signed [15:0]            recv_re_i,
  input  logic signed [15:0]            recv_im_i,
  input  logic signed [15:0]            rot_re_i,
  input  logic signed [15:0]            rot_im_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [5:0]                    symbol_index_i,
  input  logic [15:0]                   probability_i,
  input  logic                          last_i,
  output int                            fails_o,
  output int                            pending_o
);

  typedef struct packed {
    logic [5:0]  idx;
    logic [15:0] prob;
    logic        last;
  } posterior_t;

  posterior_t posteriors_q[$];
  logic [6:0]  points_r;
  logic [15:0] inv_var_r;
  logic [14:0] floor_r;
  logic signed [15:0] pt_re_r[64];
  logic signed [15:0] pt_im_r[64];

  assign pending_o = posteriors_q.size();

  function automatic longint unsigned series_exp(longint unsigned f);
    longint unsigned term;
    longint unsigned acc;
    term = 64'd1 << 30;
    acc = term;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * f) >> 16) / k;
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  function automatic longint unsigned gap_weight(logic [31:0] gap);
    longint unsigned w;
    longint unsigned e1;
    if (gap[31:16] >= 16) return 0;
    w = series_exp(gap[15:0]);
    e1 = series_exp(65536);
    for (int i = 0; i < gap[31:16]; i++) w = (w * e1 + (64'd1 << 29)) >> 30;
    return w;
  endfunction

  task automatic predict_posteriors(longint yre, longint yim, longint rre, longint rim);
    int n;
    logic [31:0] met[64];
    logic [31:0] mmin;
    longint unsigned w[64];
    longint unsigned total;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned p;
    longint unsigned sq_dist;
    longint unsigned m;
    longint xre;
    longint xim;
    longint dre;
    longint dim;
    posterior_t e;
    n = (points_r > 64) ? 64 : points_r;
    if (n == 0) return;
    mmin = 32'hFFFF_FFFF;
    for (int i = 0; i < n; i++) begin
      xre = (longint'(pt_re_r[i]) * rre - longint'(pt_im_r[i]) * rim + (1 << 13)) >>> 14;
      xim = (longint'(pt_im_r[i]) * rre + longint'(pt_re_r[i]) * rim + (1 << 13)) >>> 14;
      dre = yre - xre;
      dim = yim - xim;
      sq_dist = longint'(dre * dre) + longint'(dim * dim);
      m = (sq_dist * inv_var_r + (64'd1 << 17)) >> 18;
      if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
      met[i] = m[31:0];
      if (met[i] < mmin) mmin = met[i];
    end
    total = 0;
    for (int i = 0; i < n; i++) begin
      w[i] = gap_weight(met[i] - mmin);
      total += w[i];
    end
    lo = floor_r;
    hi = 65536 - floor_r;
    if (hi > 65535) hi = 65535;
    for (int i = 0; i < n; i++) begin
      p = ((w[i] << 16) + total / 2) / total;
      if (p < lo) p = lo;
      if (p > hi) p = hi;
      e.idx = i[5:0];
      e.prob = p[15:0];
      e.last = (i + 1 == n);
      posteriors_q.push_back(e);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    posterior_t e;
    if (!rst_ni) begin
      points_r = 7'd4;
      inv_var_r = 16'd256;
      floor_r = 15'd1;
      fails_o = 0;
      posteriors_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (posteriors_q.size() == 0) begin
          $display("%0t: unexpected item idx %0d prob %0d last %0d", $time,
                   symbol_index_i, probability_i, last_i);
          fails_o++;
        end else begin
          e = posteriors_q.pop_front();
          if (e.idx !== symbol_index_i || e.prob !== probability_i || e.last !== last_i) begin
            $display("%0t: expected idx %0d prob %0d last %0d, got idx %0d prob %0d last %0d",
                     $time, e.idx, e.prob, e.last, symbol_index_i, probability_i, last_i);
            fails_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sdm_pkg::CfgNumPoints:   points_r = cfg_data_i[6:0];
          sdm_pkg::CfgInvNoiseVar: inv_var_r = cfg_data_i;
          sdm_pkg::CfgProbFloor:   floor_r = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (!req_type_i) begin
          pt_re_r[point_index_i] = point_re_i;
          pt_im_r[point_index_i] = point_im_i;
        end else begin
          predict_posteriors(recv_re_i, recv_im_i, rot_re_i, rot_im_i);
        end
      end
    end
  end

endmodule

FILE: dv/soft_symbol_demapper_top_test.sv
// ----------------------------------------------------------------------------
// Soft symbol demapper testbench
// Loads the whole point table, runs directed extremes, then random load and
// demodulate items across several register settings and idling patterns,
// including a long output hold-off. A checker module judges every output item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module soft_symbol_demapper_top_test;

  localparam bit ReqLoad  = 1'b0;
  localparam bit ReqDemod = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [sdm_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [sdm_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = 1'b0;
  logic [5:0] point_index_i = '0;
  logic signed [15:0] point_re_i = '0, point_im_i = '0;
  logic signed [15:0] recv_re_i = '0, recv_im_i = '0;
  logic signed [15:0] rot_re_i = '0, rot_im_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [5:0] symbol_index_o;
  logic [15:0] probability_o;
  logic last_o;

  int fails, pending;
  int snd_idle = 25, rcv_idle = 70, hold_cnt = 0, quiet_cycles = 0;
  logic signed [15:0] pts_re[64], pts_im[64];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  soft_symbol_demapper_top dut (.*);

  soft_symbol_demapper_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .point_index_i,
    .point_re_i, .point_im_i, .recv_re_i, .recv_im_i, .rot_re_i, .rot_im_i,
    .out_valid_i(out_valid_o), .out_stall_i, .symbol_index_i(symbol_index_o),
    .probability_i(probability_o), .last_i(last_o),
    .fails_o(fails), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      out_stall_i = 1'b1;
      hold_cnt--;
    end else begin
      out_stall_i = ($urandom_range(99) < rcv_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 60000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(bit kind, logic [5:0] slot, logic [15:0] a, logic [15:0] b,
                      logic [15:0] c, logic [15:0] d);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    req_type_i = kind;
    point_index_i = slot;
    point_re_i = a;
    point_im_i = b;
    recv_re_i = a;
    recv_im_i = b;
    rot_re_i = c;
    rot_im_i = d;
    if (kind == ReqLoad) begin
      pts_re[slot] = a;
      pts_im[slot] = b;
    end
    in_valid_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sdm_pkg::CfgIdxW-1:0] idx,
                           logic [sdm_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [15:0] near(int center, int spread);
    return 16'(center + $urandom_range(2 * spread) - spread);
  endfunction

  task automatic random_item();
    int s;
    s = $urandom_range(63);
    if ($urandom_range(99) < 30) begin
      if ($urandom_range(99) < 60) begin
        send(ReqLoad, s[5:0], near(0, 8192), near(0, 8192), 16'd0, 16'd0);
      end else begin
        send(ReqLoad, s[5:0], 16'($urandom), 16'($urandom), 16'd0, 16'd0);
      end
    end else if ($urandom_range(99) < 65) begin
      s = $urandom_range(7);
      send(ReqDemod, 6'd0, near(pts_re[s], 600), near(pts_im[s], 600),
           near(15000, 1400), near(0, 3000));
    end else begin
      send(ReqDemod, 6'd0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int unsigned settings[6][3] = '{'{127, 65535, 32767}, '{2, 1, 0}, '{8, 256, 1},
                                    '{16, 4096, 100}, '{3, 20, 5000}, '{5, 700, 0}};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    snd_idle = 0;

    for (int i = 0; i < 64; i++) begin
      send(ReqLoad, i[5:0], near(0, 8192), near(0, 8192), 16'd0, 16'd0);
    end
    send(ReqLoad, 6'd0, 16'sh7FFF, 16'sh8000, 16'd0, 16'd0);
    send(ReqLoad, 6'd1, 16'sh8000, 16'sh7FFF, 16'd0, 16'd0);
    send(ReqLoad, 6'd2, 16'sd0, 16'sd0, 16'd0, 16'd0);
    send(ReqLoad, 6'd3, 16'sd8192, -16'sd8192, 16'd0, 16'd0);
    send(ReqDemod, 6'd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send(ReqDemod, 6'd0, 16'sd8192, -16'sd8192, 16'sd16384, 16'sd0);
    send(ReqDemod, 6'd0, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000);
    send(ReqDemod, 6'd0, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send(ReqDemod, 6'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    send(ReqDemod, 6'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    drain();
    write_reg(sdm_pkg::CfgNumPoints, 16'd0);
    send(ReqDemod, 6'd0, 16'sd100, 16'sd100, 16'sd16384, 16'sd0);
    drain();
    write_reg(sdm_pkg::CfgNumPoints, 16'd4);
    write_reg(sdm_pkg::CfgInvNoiseVar, 16'd0);
    send(ReqDemod, 6'd0, 16'sd100, -16'sd100, 16'sd16384, 16'sd0);
    drain();
    write_reg(2'd3, 16'hFFFF);
    send(ReqDemod, 6'd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(sdm_pkg::CfgNumPoints, 16'(settings[ph][0]));
      write_reg(sdm_pkg::CfgInvNoiseVar, 16'(settings[ph][1]));
      write_reg(sdm_pkg::CfgProbFloor, 16'(settings[ph][2]));
      snd_idle = (ph < 2) ? 25 : (ph < 4) ? 70 : 0;
      rcv_idle = (ph < 2) ? 70 : (ph < 4) ? 25 : 0;
      if (ph == 2) begin
        @(negedge clk_i);
        hold_cnt = 3000;
      end
      repeat (12) random_item();
      drain();
    end

    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
